// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the route table core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/dvr_pkg.sv -----
// ----------------------------------------------------------------------------
// dvr_pkg
// Types and constants of the distance-vector route table.
// ----------------------------------------------------------------------------
package dvr_pkg;
    localparam int MAX_NODES       = 16;
    localparam int NODE_BITS       = 4;
    localparam int ROUTE_COST_BITS = 12;
    localparam int LINK_COST_BITS  = 8;
    localparam int CNT_BITS        = 5;
    localparam int ENTRIES         = MAX_NODES * MAX_NODES;
    localparam int ADDR_BITS       = 2 * NODE_BITS;
    localparam int ROUTE_W         = NODE_BITS + ROUTE_COST_BITS;
    localparam logic [ROUTE_COST_BITS-1:0] COST_MAX = '1;

    typedef enum logic [1:0] {
        CMD_LINK  = 2'd0,
        CMD_RECOMP = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE, S_LINK, S_COPY_RD, S_COPY_WR, S_LC_RD, S_LC_EV,
        S_K_RD, S_K_WR, S_Q_RD, S_Q_EV
    } state_t;

    typedef struct packed {
        logic [NODE_BITS-1:0]       nh;
        logic [ROUTE_COST_BITS-1:0] cost;
    } route_t;
endpackage

// ----- rtl/distance_vector_route_table_core.sv -----
// Set-link writes the entry, then its mirror in S_LINK; a query is accepted
// in S_IDLE, then each hop passes S_Q_RD and S_Q_EV, plus output stalls;
// recompute copies the table (S_COPY_RD, S_COPY_WR per entry), then per round
// visits each (i,j) pair and, if linked, each k (S_K_RD, S_K_WR). One request
// at a time, with one shared compare-add step on the route RAM ports. Reset
// (rst_n low, asynchronous) clears all links and marks the route table unreachable.
// ----------------------------------------------------------------------------
// distance_vector_route_table_core
// Link topology, iterative route relaxation and next-hop path walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module distance_vector_route_table_core
    import dvr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       node_count_we,
    input  logic [CNT_BITS-1:0]        node_count_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  logic [NODE_BITS-1:0]       node_a,
    input  logic [NODE_BITS-1:0]       node_b,
    input  logic [LINK_COST_BITS-1:0]  link_cost,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [NODE_BITS-1:0]       hop_node,
    output logic [ROUTE_COST_BITS-1:0] route_cost,
    output logic                       reachable,
    output logic                       path_loop,
    output logic                       last
);
    state_t state_reg, state_next;

    logic [CNT_BITS-1:0]        node_count_reg;
    logic [NODE_BITS-1:0]       a_reg, a_next, b_reg, b_next;
    logic [NODE_BITS-1:0]       i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [NODE_BITS-1:0]       r_reg, r_next;
    logic [ADDR_BITS-1:0]       cnt_reg, cnt_next;
    logic [LINK_COST_BITS-1:0]  lc_reg, lc_next;
    logic [ROUTE_COST_BITS-1:0] qcost_reg, qcost_next;
    logic                       routes_valid_reg, routes_valid_next;
    logic [ENTRIES-1:0]         topo_vld_reg;
    logic                       topo_vld_q_reg;

    logic                       ov_reg, ov_next, loop_reg, loop_next;
    logic                       reach_reg, reach_next, last_reg, last_next;
    logic [NODE_BITS-1:0]       hop_reg, hop_next;
    logic [ROUTE_COST_BITS-1:0] cost_reg, cost_next;

    // Topology RAM and two identical copies of the route RAM, so that the
    // relaxation step can read the i and j rows in the same cycle.
    logic                       t_we, r_we;
    logic [ADDR_BITS-1:0]       t_waddr, t_raddr, r_waddr, ra_addr, rb_addr;
    logic [LINK_COST_BITS-1:0]  t_wdata, t_q, lc_rd;
    route_t                     r_wdata, qa, qb;

    dvr_ram #(.WIDTH(LINK_COST_BITS), .DEPTH(ENTRIES)) u_topo (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_q)
    );
    dvr_ram #(.WIDTH(ROUTE_W), .DEPTH(ENTRIES)) u_route_a (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(ra_addr), .rdata(qa)
    );
    dvr_ram #(.WIDTH(ROUTE_W), .DEPTH(ENTRIES)) u_route_b (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(rb_addr), .rdata(qb)
    );

    // A topology entry that was never written reads as no link.
    assign lc_rd = topo_vld_q_reg ? t_q : '0;

    // Active node count saturates at the table size; rounds are half of it.
    logic [CNT_BITS-1:0]  n_sat;
    logic [NODE_BITS-1:0] n_m1, rounds;
    logic                 i_last, j_last, k_last, r_last, in_acc;
    assign n_sat  = (node_count_reg > CNT_BITS'(MAX_NODES)) ?
                    CNT_BITS'(MAX_NODES) : node_count_reg;
    assign n_m1   = n_sat[NODE_BITS-1:0] - 1'b1;
    assign rounds = n_sat[CNT_BITS-1:1];
    assign i_last = (i_reg == n_m1);
    assign j_last = (j_reg == n_m1);
    assign k_last = (k_reg == n_m1);
    assign r_last = (r_reg == rounds - 1'b1);
    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;

    // Saturating sums used by the relaxation step.
    logic [ROUTE_COST_BITS:0]   sum_d, sum_c;
    logic [ROUTE_COST_BITS-1:0] s1, s2;
    assign sum_d = {1'b0, qb.cost} + (ROUTE_COST_BITS+1)'(lc_reg);
    assign sum_c = {1'b0, qa.cost} + (ROUTE_COST_BITS+1)'(lc_reg);
    assign s1 = sum_d[ROUTE_COST_BITS] ? COST_MAX : sum_d[ROUTE_COST_BITS-1:0];
    assign s2 = sum_c[ROUTE_COST_BITS] ? COST_MAX : sum_c[ROUTE_COST_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            node_count_reg   <= CNT_BITS'(MAX_NODES);
            routes_valid_reg <= 1'b0;
            topo_vld_reg     <= '0;
            ov_reg           <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            routes_valid_reg <= routes_valid_next;
            ov_reg           <= ov_next;
            if (node_count_we)
            begin
                node_count_reg <= node_count_wdata;
            end
            if (t_we)
            begin
                topo_vld_reg[t_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        k_reg          <= k_next;
        r_reg          <= r_next;
        cnt_reg        <= cnt_next;
        lc_reg         <= lc_next;
        qcost_reg      <= qcost_next;
        hop_reg        <= hop_next;
        cost_reg       <= cost_next;
        reach_reg      <= reach_next;
        loop_reg       <= loop_next;
        last_reg       <= last_next;
        topo_vld_q_reg <= topo_vld_reg[t_raddr];
    end

    always_comb
    begin
        logic adv_j, adv_k, done;
        adv_j = 1'b0;
        adv_k = 1'b0;
        done  = 1'b0;

        state_next        = state_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        r_next            = r_reg;
        cnt_next          = cnt_reg;
        lc_next           = lc_reg;
        qcost_next        = qcost_reg;
        routes_valid_next = routes_valid_reg;
        ov_next           = ov_reg && !out_ready;
        hop_next          = hop_reg;
        cost_next         = cost_reg;
        reach_next        = reach_reg;
        loop_next         = loop_reg;
        last_next         = last_reg;

        t_we    = 1'b0;
        t_waddr = {node_a, node_b};
        t_wdata = link_cost;
        t_raddr = {i_reg, j_reg};
        r_we    = 1'b0;
        r_waddr = {i_reg, k_reg};
        r_wdata = '0;
        ra_addr = {i_reg, k_reg};
        rb_addr = {j_reg, k_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    a_next = node_a;
                    b_next = node_b;
                    case (cmd_t'(command))
                        CMD_LINK:
                        begin
                            // First half of the symmetric write; the mirror
                            // entry follows in the next cycle.
                            t_we       = 1'b1;
                            state_next = S_LINK;
                        end
                        CMD_RECOMP:
                        begin
                            cnt_next   = '0;
                            state_next = S_COPY_RD;
                        end
                        CMD_QUERY:
                        begin
                            i_next     = '0;
                            state_next = S_Q_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LINK:
            begin
                t_we       = 1'b1;
                t_waddr    = {b_reg, a_reg};
                t_wdata    = lc_reg;
                state_next = S_IDLE;
            end
            S_COPY_RD:
            begin
                t_raddr    = cnt_reg;
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                t_raddr      = cnt_reg;
                r_we         = 1'b1;
                r_waddr      = cnt_reg;
                r_wdata.cost = ROUTE_COST_BITS'(lc_rd);
                r_wdata.nh   = (lc_rd != '0) ? cnt_reg[NODE_BITS-1:0] : '0;
                cnt_next     = cnt_reg + 1'b1;
                state_next   = S_COPY_RD;
                if (cnt_reg == '1)
                begin
                    routes_valid_next = 1'b1;
                    i_next = '0;
                    j_next = '0;
                    r_next = '0;
                    state_next = (rounds == '0) ? S_IDLE : S_LC_RD;
                end
            end
            S_LC_RD:
            begin
                // Link cost of (i,j) and, for the diagonal, the route entry.
                ra_addr    = {i_reg, j_reg};
                state_next = S_LC_EV;
            end
            S_LC_EV:
            begin
                if (i_reg == j_reg)
                begin
                    r_we       = 1'b1;
                    r_waddr    = {i_reg, i_reg};
                    r_wdata.nh = i_reg;
                    r_wdata.cost = qa.cost;
                    adv_j      = 1'b1;
                end
                else if (lc_rd == '0)
                begin
                    adv_j = 1'b1;
                end
                else
                begin
                    lc_next    = lc_rd;
                    k_next     = '0;
                    state_next = S_K_RD;
                end
            end
            S_K_RD:
            begin
                if (k_reg == i_reg || k_reg == j_reg)
                begin
                    adv_k = 1'b1;
                end
                else
                begin
                    state_next = S_K_WR;
                end
            end
            S_K_WR:
            begin
                // One compare-add step: offer j's route to i and i's to j.
                adv_k = 1'b1;
                if (qa.cost == '0 && qb.cost == '0)
                begin
                    r_we = 1'b0;
                end
                else if (qa.cost == '0 || (qb.cost != '0 && qa.cost > s1))
                begin
                    r_we    = 1'b1;
                    r_waddr = {i_reg, k_reg};
                    r_wdata = '{nh: j_reg, cost: s1};
                end
                else if (qb.cost == '0 || s2 < qb.cost)
                begin
                    r_we    = 1'b1;
                    r_waddr = {j_reg, k_reg};
                    r_wdata = '{nh: i_reg, cost: s2};
                end
                else if (qa.cost == s1)
                begin
                    r_we    = (qa.nh > j_reg);
                    r_waddr = {i_reg, k_reg};
                    r_wdata = '{nh: j_reg, cost: qa.cost};
                end
                else if (s2 == qb.cost)
                begin
                    r_we    = (i_reg < qb.nh);
                    r_waddr = {j_reg, k_reg};
                    r_wdata = '{nh: i_reg, cost: qb.cost};
                end
            end
            S_Q_RD:
            begin
                // i_reg holds the step count of the walk, k_reg the hop.
                ra_addr    = (i_reg == '0) ? {a_reg, b_reg} : {k_reg, b_reg};
                state_next = S_Q_EV;
            end
            S_Q_EV:
            begin
                // The read address is held so the entry survives output stalls.
                ra_addr = (i_reg == '0) ? {a_reg, b_reg} : {k_reg, b_reg};
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    hop_next = (i_reg == '0) ? a_reg : k_reg;
                    cost_next = (i_reg == '0) ? qa.cost : qcost_reg;
                    loop_next = 1'b0;
                    if (i_reg == '0 && (!routes_valid_reg || qa.cost == '0))
                    begin
                        cost_next  = '0;
                        reach_next = 1'b0;
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        reach_next = 1'b1;
                        if (i_reg == '0)
                        begin
                            qcost_next = qa.cost;
                        end
                        if (qa.nh == b_reg)
                        begin
                            last_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (i_reg == NODE_BITS'(MAX_NODES - 1))
                        begin
                            loop_next  = 1'b1;
                            last_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            last_next  = 1'b0;
                            k_next     = qa.nh;
                            i_next     = i_reg + 1'b1;
                            state_next = S_Q_RD;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv_k)
        begin
            if (k_last)
            begin
                adv_j = 1'b1;
            end
            else
            begin
                k_next     = k_reg + 1'b1;
                state_next = S_K_RD;
            end
        end
        if (adv_j)
        begin
            state_next = S_LC_RD;
            if (j_last)
            begin
                j_next = '0;
                if (i_last)
                begin
                    i_next = '0;
                    if (r_last)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            else
            begin
                j_next = j_reg + 1'b1;
            end
        end
        if (done)
        begin
            state_next = S_IDLE;
        end
        // The link cost of a set-link request is kept for its mirror write.
        if (in_acc)
        begin
            lc_next = link_cost;
        end
    end

    assign out_valid  = ov_reg;
    assign hop_node   = hop_reg;
    assign route_cost = cost_reg;
    assign reachable  = reach_reg;
    assign path_loop  = loop_reg;
    assign last       = last_reg;

    `ASSERT_RST(a_kwr_after_krd, clk, rst_n, state_reg == S_K_WR |-> $past(state_reg) == S_K_RD, "compare-add step without its read")
    `ASSERT_RST(a_routes_stay, clk, rst_n, !$fell(routes_valid_reg), "route table lost its valid mark")
    `ASSERT_RST(a_loop_last, clk, rst_n, ov_reg && loop_reg |-> last_reg && reach_reg, "loop flag on a non-final result")
    `ASSERT_RST(a_recomp_start, clk, rst_n, in_acc && command == CMD_RECOMP |=> state_reg == S_COPY_RD, "recompute did not start the copy")
endmodule

// ----- rtl/dvr_ram.sv -----
// ----------------------------------------------------------------------------
// dvr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dvr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table core testbench
// Drives link, recompute, query and idle requests with random idling on both
// channels, predicts every path hop from a private copy of the topology and
// route table, and checks each returned hop in order.
// ----------------------------------------------------------------------------
module tb
    import dvr_pkg::*;
;

    typedef struct packed {
        logic [3:0]  hop;
        logic [11:0] cost;
        logic        reach;
        logic        loop_flag;
        logic        lst;
    } hop_t;

    // Scoreboard: keeps its own copy of the block's tables and the hops that
    // the requests accepted so far should produce.
    class route_scoreboard;
        logic [7:0]  topo [16][16];
        logic [11:0] rcost [16][16];
        logic [3:0]  nhop [16][16];
        int          nodes;
        hop_t        pending_hops [$];
        int          errors;

        function new();
            for (int i = 0; i < 16; i++)
                for (int j = 0; j < 16; j++)
                begin
                    topo[i][j] = '0;
                    rcost[i][j] = '0;
                    nhop[i][j] = '0;
                end
            nodes = 16;
            errors = 0;
        endfunction

        function void add_hop(hop_t h);
            pending_hops = {pending_hops, h};
        endfunction

        function logic [11:0] sat(logic [11:0] x, logic [11:0] y);
            logic [12:0] s;
            s = x + y;
            return s[12] ? 12'hFFF : s[11:0];
        endfunction

        function void relax();
            int n;
            logic [11:0] lc, c, d;
            n = nodes > 16 ? 16 : nodes;
            for (int i = 0; i < 16; i++)
                for (int j = 0; j < 16; j++)
                begin
                    rcost[i][j] = topo[i][j];
                    nhop[i][j] = topo[i][j] != 0 ? j[3:0] : 4'd0;
                end
            for (int r = 0; r < n / 2; r++)
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++)
                    begin
                        if (i == j)
                        begin
                            nhop[i][i] = i[3:0];
                            continue;
                        end
                        lc = topo[i][j];
                        if (lc == 0)
                            continue;
                        for (int k = 0; k < n; k++)
                        begin
                            if (k == i || k == j)
                                continue;
                            c = rcost[i][k];
                            d = rcost[j][k];
                            if (c == 0 && d == 0)
                                continue;
                            if (c == 0)
                            begin
                                rcost[i][k] = sat(lc, d);
                                nhop[i][k] = j[3:0];
                            end
                            else if (d == 0)
                            begin
                                rcost[j][k] = sat(lc, c);
                                nhop[j][k] = i[3:0];
                            end
                            else if (c > sat(lc, d))
                            begin
                                rcost[i][k] = sat(lc, d);
                                nhop[i][k] = j[3:0];
                            end
                            else if (sat(c, lc) < d)
                            begin
                                rcost[j][k] = sat(lc, c);
                                nhop[j][k] = i[3:0];
                            end
                            else if (c == sat(lc, d))
                            begin
                                if (nhop[i][k] > j)
                                    nhop[i][k] = j[3:0];
                            end
                            else if (sat(c, lc) == d)
                            begin
                                if (i < nhop[j][k])
                                    nhop[j][k] = i[3:0];
                            end
                        end
                    end
        endfunction

        function void note_request(cmd_t cmd, logic [3:0] a, logic [3:0] b,
                                   logic [7:0] lc);
            logic [3:0] cur, nx;
            logic [11:0] cost;
            int cnt;
            case (cmd)
                CMD_LINK:
                begin
                    topo[a][b] = lc;
                    topo[b][a] = lc;
                end
                CMD_RECOMP: relax();
                CMD_QUERY:
                begin
                    cost = rcost[a][b];
                    if (cost == 0)
                        add_hop({a, 12'd0, 1'b0, 1'b0, 1'b1});
                    else
                    begin
                        cur = a;
                        cnt = 0;
                        forever
                        begin
                            nx = nhop[cur][b];
                            if (nx == b)
                            begin
                                add_hop({cur, cost, 1'b1, 1'b0, 1'b1});
                                break;
                            end
                            if (cnt + 1 >= 16)
                            begin
                                add_hop({cur, cost, 1'b1, 1'b1, 1'b1});
                                break;
                            end
                            add_hop({cur, cost, 1'b1, 1'b0, 1'b0});
                            cnt++;
                            cur = nx;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_hop(hop_t got);
            hop_t want;
            if (pending_hops.size() == 0)
            begin
                $error("unexpected hop %h", got);
                errors++;
                return;
            end
            want = pending_hops.pop_front();
            if (got.hop !== want.hop)
            begin
                $error("hop_node exp %0d got %0d", want.hop, got.hop);
                errors++;
            end
            if (got.cost !== want.cost)
            begin
                $error("route_cost exp %0d got %0d", want.cost, got.cost);
                errors++;
            end
            if (got.reach !== want.reach)
            begin
                $error("reachable exp %0d got %0d", want.reach, got.reach);
                errors++;
            end
            if (got.loop_flag !== want.loop_flag)
            begin
                $error("path_loop exp %0d got %0d", want.loop_flag, got.loop_flag);
                errors++;
            end
            if (got.lst !== want.lst)
            begin
                $error("last exp %0d got %0d", want.lst, got.lst);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        node_count_we;
    logic [4:0]  node_count_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [3:0]  node_a;
    logic [3:0]  node_b;
    logic [7:0]  link_cost;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  hop_node;
    logic [11:0] route_cost;
    logic        reachable;
    logic        path_loop;
    logic        last;

    route_scoreboard sb;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    longint unsigned cycle_count;

    distance_vector_route_table_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .node_count_we(node_count_we), .node_count_wdata(node_count_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .node_a(node_a), .node_b(node_b), .link_cost(link_cost),
        .out_valid(out_valid), .out_ready(out_ready),
        .hop_node(hop_node), .route_cost(route_cost), .reachable(reachable),
        .path_loop(path_loop), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit: even a run of nothing but recomputes at 16 nodes, with stalls,
    // fits under this bound.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 64'd20_000_000)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result side: random stalls driven at the falling edge, hops checked at
    // the rising edge where the handshake completes.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_hop({hop_node, route_cost, reachable, path_loop, last});
    end

    // Sends one request; the prediction is made when it is accepted. Valid
    // of the previous request is dropped here, or replaced by the next one.
    task automatic send_request(cmd_t cmd, logic [3:0] a, logic [3:0] b, logic [7:0] lc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        node_a <= a;
        node_b <= b;
        link_cost <= lc;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(cmd, a, b, lc);
        @(negedge clk);
    endtask

    // Waits until every predicted hop has arrived and the block is idle, so
    // a register write lands while nothing is in flight.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending_hops.size() != 0 || !in_ready)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_node_count(logic [4:0] v);
        drain();
        node_count_we <= 1'b1;
        node_count_wdata <= v;
        @(negedge clk);
        node_count_we <= 1'b0;
        sb.nodes = int'(v);
    endtask

    // Mostly in-range links and queries; recompute is rare because it is
    // slow, and the idle command shows up as noise.
    task automatic random_phase(int count, int n);
        int pick;
        logic [3:0] a, b;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            a = (n > 0 && $urandom_range(9) != 0) ? 4'($urandom_range(n - 1)) : 4'($urandom);
            b = (n > 0 && $urandom_range(9) != 0) ? 4'($urandom_range(n - 1)) : 4'($urandom);
            if (pick < 45)
                send_request(CMD_LINK, a, b,
                             $urandom_range(3) == 0 ? 8'd0 : 8'($urandom));
            else if (pick < 52)
                send_request(CMD_RECOMP, a, b, 8'($urandom));
            else if (pick < 96)
                send_request(CMD_QUERY, a, b, 8'($urandom));
            else
                send_request(CMD_NONE, a, b, 8'($urandom));
        end
        send_request(CMD_RECOMP, 4'd0, 4'd0, 8'd0);
        for (int i = 0; i < 4; i++)
            send_request(CMD_QUERY, 4'($urandom_range(n - 1)), 4'($urandom_range(n - 1)),
                         8'd0);
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        node_count_we = 1'b0;
        node_count_wdata = '0;
        in_valid = 1'b0;
        command = '0;
        node_a = '0;
        node_b = '0;
        link_cost = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: unreachable query at reset, a chain with a tie, a
        // self-link, the extremes of cost and the idle command.
        send_request(CMD_QUERY, 4'd0, 4'd15, 8'd0);
        send_request(CMD_LINK, 4'd0, 4'd1, 8'd1);
        send_request(CMD_LINK, 4'd1, 4'd2, 8'd255);
        send_request(CMD_LINK, 4'd2, 4'd15, 8'd255);
        send_request(CMD_LINK, 4'd0, 4'd3, 8'd128);
        send_request(CMD_LINK, 4'd3, 4'd2, 8'd128);
        send_request(CMD_LINK, 4'd5, 4'd5, 8'd7);
        send_request(CMD_LINK, 4'd9, 4'd10, 8'd255);
        send_request(CMD_LINK, 4'd9, 4'd10, 8'd0);
        send_request(CMD_NONE, 4'd15, 4'd15, 8'd255);
        send_request(CMD_QUERY, 4'd0, 4'd1, 8'd0);
        send_request(CMD_RECOMP, 4'd0, 4'd0, 8'd0);
        send_request(CMD_QUERY, 4'd0, 4'd15, 8'd0);
        send_request(CMD_QUERY, 4'd15, 4'd0, 8'd0);
        send_request(CMD_QUERY, 4'd5, 4'd5, 8'd0);
        send_request(CMD_QUERY, 4'd4, 4'd4, 8'd0);
        send_request(CMD_QUERY, 4'd0, 4'd2, 8'd0);
        send_request(CMD_QUERY, 4'd9, 4'd10, 8'd255);

        // Node count 1 runs no rounds and copies the topology as is; 31 saturates to 16.
        write_node_count(5'd1);
        send_request(CMD_RECOMP, 4'd0, 4'd0, 8'd0);
        send_request(CMD_QUERY, 4'd0, 4'd2, 8'd0);
        write_node_count(5'd31);
        send_request(CMD_RECOMP, 4'd0, 4'd0, 8'd0);
        send_request(CMD_QUERY, 4'd0, 4'd15, 8'd0);

        // Random phases with the four idling profiles and several counts.
        write_node_count(5'd4);
        random_phase(12, 4);
        send_idle_pct = 81;
        write_node_count(5'd6);
        random_phase(12, 6);
        send_idle_pct = 0;
        recv_stall_pct = 81;
        write_node_count(5'd16);
        random_phase(12, 16);
        send_idle_pct = 37;
        recv_stall_pct = 37;
        write_node_count(5'd0);
        random_phase(6, 16);
        write_node_count(5'd8);
        random_phase(10, 8);

        drain();
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
